>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, silent while reset is held
`define KSNN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, silent while reset is held
`define KSNN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ksnn_pkg.sv
// shared types, codes and key tables for the key signature note number block
package ksnn_pkg;

	// item kinds
	localparam logic OP_RECORD  = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// accidental codes
	localparam logic [2:0] ACC_NONE    = 3'd0;
	localparam logic [2:0] ACC_SHARP   = 3'd1;
	localparam logic [2:0] ACC_DSHARP  = 3'd2;
	localparam logic [2:0] ACC_FLAT    = 3'd3;
	localparam logic [2:0] ACC_DFLAT   = 3'd4;
	localparam logic [2:0] ACC_NATURAL = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_TONIC = 2'd0;
	localparam logic [1:0] CFG_SHARP = 2'd1;
	localparam logic [1:0] CFG_FLAT  = 2'd2;
	localparam logic [1:0] CFG_MODE  = 2'd3;

	localparam int unsigned NUM_LETTERS = 7;
	localparam logic [2:0]  LETTER_NONE = 3'd7;

	typedef logic signed [2:0] alter_t;

	// key signature as shown on every result
	typedef struct packed {
		logic signed [3:0] fifths;
		logic              minor;
		logic              unusual;
	} key_info_t;

	// write request into the alteration table
	typedef struct packed {
		logic       en;
		logic [2:0] idx;
		alter_t     val;
	} tbl_wr_t;

	localparam logic signed [3:0] TONIC_FIFTHS [8] = '{
		4'sd0, 4'sd2, 4'sd4, -4'sd1, 4'sd1, 4'sd3, 4'sd5, 4'sd0
	};

	localparam logic signed [3:0] MODE_SHIFT [16] = '{
		4'sd0, -4'sd3, 4'sd0, -4'sd3, -4'sd1, -4'sd2, -4'sd4, 4'sd1,
		-4'sd5, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0
	};

	localparam logic [3:0] MODE_MINOR = 4'd1;

	// position of each letter in the order sharps and flats are added
	localparam logic [2:0] SHARP_RANK [7] = '{3'd1, 3'd3, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6};
	localparam logic [2:0] FLAT_RANK  [7] = '{3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};

	localparam logic [3:0] NATURAL_PITCH [8] = '{
		4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0
	};

	// alteration a key signature puts on one letter
	function automatic alter_t key_alter(input logic signed [3:0] sf, input logic [2:0] idx);
		logic signed [4:0] sf5;
		logic signed [4:0] srank;
		logic signed [4:0] frank;
		alter_t            res;
		sf5   = 5'(sf);
		srank = $signed({2'b00, SHARP_RANK[idx]});
		frank = $signed({2'b00, FLAT_RANK[idx]});
		res   = 3'sd0;
		if (srank < sf5)
			res = 3'sd1;
		if (frank < -sf5)
			res = -3'sd1;
		return res;
	endfunction

endpackage

>>> src/key_signature_note_number.sv
// top level of the key signature note number block
// Turns note events into MIDI note numbers under a configured key. The key is
// set by four registers (tonic letter, sharp, flat, mode) written through the
// cfg port; each write takes effect at once, recomputes the signed key
// signature and reloads the seven-entry letter alteration table, dropping
// accidentals recorded earlier. Each input transfer is either a record item
// (tuser 0), which stores an explicit accidental for its letter, or a compute
// item (tuser 1), which returns natural pitch plus accidental (or the stored
// alteration when none is given) plus (octave+2)*12. Every item yields exactly
// one result transfer carrying the note number (zero for record items) and the
// current key signature. Throughput is one item per clock while the result
// side is not stalled. The transfer loads the input register, and the item
// moves into the result register once that register is free or being
// drained; the table read and the note add sit between the two registers. A
// record item updates the table as it leaves the input register, so the very
// next item already sees it.
module key_signature_note_number import ksnn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [3:0]  cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // letter[2:0], accidental[5:3], octave[10:6], zero pad
	input  logic        s_tuser,   // mode: 0 record, 1 compute
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // note_number[8:0], key_fifths[12:9], key_minor[13],
	                               // unusual_key[14], zero pad
);

	key_info_t         key_info;
	logic              load;
	logic signed [3:0] load_fifths;

	// input register stage
	logic              valid_s1;
	logic              op_s1;
	logic [2:0]        letter_s1;
	logic [2:0]        acc_s1;
	logic signed [4:0] oct_s1;

	// result register stage
	logic              valid_s2;
	logic signed [8:0] note_s2;
	key_info_t         info_s2;

	logic              advance;
	logic              in_xfer;
	alter_t            stored_alter;
	logic signed [8:0] note_calc;
	tbl_wr_t           calc_wr;
	tbl_wr_t           tbl_wr;

	ksnn_keysig u_keysig (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.key_info    (key_info),
		.load        (load),
		.load_fifths (load_fifths)
	);

	ksnn_alter_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_fifths (load_fifths),
		.wr          (tbl_wr),
		.rd_idx      (letter_s1),
		.rd_alter    (stored_alter)
	);

	ksnn_note_calc u_calc (
		.op           (op_s1),
		.letter       (letter_s1),
		.accidental   (acc_s1),
		.octave       (oct_s1),
		.stored_alter (stored_alter),
		.note_number  (note_calc),
		.wr           (calc_wr)
	);

	// the staged item moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	// table write only when the record item actually leaves the input stage
	always_comb begin
		tbl_wr    = calc_wr;
		tbl_wr.en = calc_wr.en && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !m_tready);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1     <= s_tuser;
			letter_s1 <= s_tdata[2:0];
			acc_s1    <= s_tdata[5:3];
			oct_s1    <= s_tdata[10:6];
		end
		if (advance) begin
			note_s2 <= note_calc;
			info_s2 <= key_info;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, info_s2.unusual, info_s2.minor, info_s2.fifths, note_s2};

endmodule

>>> src/ksnn_keysig.sv
// configuration registers and key signature derivation
module ksnn_keysig import ksnn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [3:0]        cfg_wdata,
	output key_info_t         key_info,
	output logic              load,
	output logic signed [3:0] load_fifths
);

	logic [2:0] tonic_q, tonic_d;
	logic       sharp_q, sharp_d;
	logic       flat_q, flat_d;
	logic [3:0] mode_q, mode_d;
	key_info_t  info_q, info_d;
	logic signed [4:0] raw;
	logic signed [4:0] acc7;

	always_comb begin
		tonic_d = tonic_q;
		sharp_d = sharp_q;
		flat_d  = flat_q;
		mode_d  = mode_q;
		if (cfg_we) begin
			unique case (cfg_addr)
				CFG_TONIC: tonic_d = cfg_wdata[2:0];
				CFG_SHARP: sharp_d = cfg_wdata[0];
				CFG_FLAT:  flat_d  = cfg_wdata[0];
				CFG_MODE:  mode_d  = cfg_wdata;
				default:   ;
			endcase
		end
	end

	// signature of the configuration as it stands after this cycle's write
	always_comb begin
		priority if (sharp_d)
			acc7 = 5'sd7;
		else if (flat_d)
			acc7 = -5'sd7;
		else
			acc7 = 5'sd0;
		raw = 5'(TONIC_FIFTHS[tonic_d]) + acc7 + 5'(MODE_SHIFT[mode_d]);
		info_d.unusual = (raw < -5'sd7) || (raw > 5'sd7);
		priority if (raw < -5'sd7)
			info_d.fifths = 4'(raw + 5'sd12);
		else if (raw > 5'sd7)
			info_d.fifths = 4'(raw - 5'sd12);
		else
			info_d.fifths = raw[3:0];
		info_d.minor = (mode_d == MODE_MINOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tonic_q <= '0;
			sharp_q <= 1'b0;
			flat_q  <= 1'b0;
			mode_q  <= '0;
			info_q  <= '0;
		end else if (cfg_we) begin
			tonic_q <= tonic_d;
			sharp_q <= sharp_d;
			flat_q  <= flat_d;
			mode_q  <= mode_d;
			info_q  <= info_d;
		end
	end

	assign key_info    = info_q;
	assign load        = cfg_we;
	assign load_fifths = info_d.fifths;

endmodule

>>> src/ksnn_alter_table.sv
// seven-entry letter alteration table, reloaded from the key signature
module ksnn_alter_table import ksnn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic signed [3:0] load_fifths,
	input  tbl_wr_t           wr,
	input  logic [2:0]        rd_idx,
	output alter_t            rd_alter
);

	alter_t alter_q [NUM_LETTERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++)
				alter_q[i] <= 3'sd0;
		end else if (load) begin
			for (int i = 0; i < NUM_LETTERS; i++)
				alter_q[i] <= key_alter(load_fifths, 3'(i));
		end else if (wr.en && wr.idx != LETTER_NONE) begin
			alter_q[wr.idx] <= wr.val;
		end
	end

	// letter seven has no entry and reads as unaltered
	assign rd_alter = (rd_idx == LETTER_NONE) ? 3'sd0 : alter_q[rd_idx];

endmodule

>>> src/ksnn_note_calc.sv
// note number arithmetic and accidental decode for one item
module ksnn_note_calc import ksnn_pkg::*; (
	input  logic              op,
	input  logic [2:0]        letter,
	input  logic [2:0]        accidental,
	input  logic signed [4:0] octave,
	input  alter_t            stored_alter,
	output logic signed [8:0] note_number,
	output tbl_wr_t           wr
);

	alter_t            given;
	logic              given_ok;
	alter_t            used;
	logic signed [8:0] oct2;
	logic signed [8:0] note;

	always_comb begin
		given_ok = 1'b1;
		unique case (accidental)
			ACC_SHARP:   given = 3'sd1;
			ACC_DSHARP:  given = 3'sd2;
			ACC_FLAT:    given = -3'sd1;
			ACC_DFLAT:   given = -3'sd2;
			ACC_NATURAL: given = 3'sd0;
			default: begin
				given    = 3'sd0;
				given_ok = 1'b0;
			end
		endcase
		used = (accidental == ACC_NONE) ? stored_alter : given;
		oct2 = 9'(octave) + 9'sd2;
		// times twelve as eight plus four
		note = $signed({1'b0, 4'b0, NATURAL_PITCH[letter]}) + 9'(used)
			+ (oct2 <<< 3) + (oct2 <<< 2);
		note_number = (op == OP_COMPUTE) ? note : 9'sd0;
		wr.en  = (op == OP_RECORD) && given_ok && (letter != LETTER_NONE);
		wr.idx = letter;
		wr.val = given;
	end

endmodule

>>> src/ksnn_checker.sv
// port-level checker for the key signature note number block, with its bind
`include "assert_macros.svh"

module ksnn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result keeps its payload
	`KSNN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// wrapped key signature never shows the value minus eight
	`KSNN_ASSERT_NOW(a_fifths_range, m_tvalid, m_tdata[12:9] != 4'b1000, "key signature out of range")

	// input side only stalls while a result is waiting
	`KSNN_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with empty result register")

	// a fresh result needs an input transfer that went through the input register into the result register
	`KSNN_ASSERT_NOW(a_no_invent, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without input transfer")

endmodule

bind key_signature_note_number ksnn_checker u_ksnn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
